FILE: rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under reset.
`define ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication under reset.
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

FILE: rtl/metf_pkg.sv
// Types and constants of the encoder feedback tracker.
`timescale 1ns / 1ps
`default_nettype none

package metf_pkg;

  // Input op codes
  localparam logic OP_FEEDBACK = 1'b0;
  localparam logic OP_SETUP    = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNTS_PER_REV    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEGREES_PER_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_CAN_ID       = 2'd2;

  localparam logic [15:0] CPR_RESET  = 16'd8192;
  localparam logic [23:0] DPC_RESET  = 24'd737280;
  localparam logic [10:0] BASE_RESET = 11'd513;

  // Unwrap edges
  localparam logic [12:0] EDGE_HIGH = 13'd7000;
  localparam logic [12:0] EDGE_LOW  = 13'd1000;

  // Gear ratio division by reciprocal: q = (v * RECIP) >> SHIFT, exact for v < 2**24
  localparam logic [23:0] ROUND19  = 24'd9;
  localparam logic [23:0] ROUND36  = 24'd18;
  localparam logic [31:0] RECIP19  = 32'd28256364;
  localparam logic [31:0] RECIP36  = 32'd29826162;
  localparam int          SHIFT19  = 29;
  localparam int          SHIFT36  = 30;

  // Wrap to one turn: 360 deg Q.16 = 45 << 19, residue mod 45 by reciprocal
  localparam logic signed [24:0] HALF_TURN_Q16 = 25'sd11796480;
  localparam logic [5:0]  MOD_DIV    = 6'd45;
  localparam logic [30:0] MOD_OFFSET = 31'd536870925;  // 45 * 11930465, keeps value positive
  localparam logic [31:0] RECIP45    = 32'd3054198967;
  localparam int          SHIFT45    = 37;
  localparam int          FRAC_W     = 19;

  typedef enum logic [1:0] {
    KIND_UNKNOWN = 2'd0,
    KIND_DIRECT  = 2'd1,
    KIND_RATIO19 = 2'd2,
    KIND_RATIO36 = 2'd3
  } metf_kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_UNWRAP,
    S_ANGLE,
    S_TOTAL,
    S_WRAP,
    S_DIV,
    S_RECIP,
    S_QMUL,
    S_FINISH
  } metf_state_e;

  typedef struct packed {
    logic [12:0] pos;
    logic [31:0] cnt;
  } metf_fb_rec_t;

  typedef struct packed {
    metf_kind_e  kind;
    logic [31:0] zero;
  } metf_set_rec_t;

endpackage

`default_nettype wire

FILE: rtl/metf_if.sv
// Channel interfaces: input items, result items and configuration writes.
`timescale 1ns / 1ps
`default_nettype none

interface metf_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic [1:0]         bus;
  logic [10:0]        can_id;
  logic [12:0]        encoder_position;
  logic signed [15:0] rotor_rpm;
  logic signed [15:0] current;
  logic [7:0]         temperature;
  logic [1:0]         motor_kind;
  logic signed [31:0] zero_deg;

  modport source (
    output valid, op, bus, can_id, encoder_position, rotor_rpm, current,
           temperature, motor_kind, zero_deg,
    input  ready
  );
  modport sink (
    input  valid, op, bus, can_id, encoder_position, rotor_rpm, current,
           temperature, motor_kind, zero_deg,
    output ready
  );
endinterface

interface metf_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         out_bus;
  logic [3:0]         motor_index;
  logic signed [31:0] turn_count;
  logic signed [47:0] total_angle;
  logic signed [24:0] relative_angle;
  logic signed [23:0] shaft_speed;
  logic signed [15:0] out_rotor_rpm;
  logic signed [15:0] out_current;
  logic [7:0]         out_temperature;

  modport source (
    output valid, out_bus, motor_index, turn_count, total_angle, relative_angle,
           shaft_speed, out_rotor_rpm, out_current, out_temperature,
    input  ready
  );
  modport sink (
    input  valid, out_bus, motor_index, turn_count, total_angle, relative_angle,
           shaft_speed, out_rotor_rpm, out_current, out_temperature,
    output ready
  );
endinterface

interface metf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [23:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/metf_mul.sv
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps
`default_nettype none

module metf_mul (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [32:0] a_i,
  input  logic signed [32:0] b_i,
  output logic signed [65:0] p_o
);

  logic signed [65:0] p_q;

  // Product holds while disabled
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

FILE: rtl/metf_store.sv
// Per-slot state memories with valid bits; unwritten slots read as zero.
`timescale 1ns / 1ps
`default_nettype none

module metf_store #(
  parameter int NSLOTS = 33,
  parameter int SLOT_W = 6
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    rd_en_i,
  input  logic [SLOT_W-1:0]       rd_addr_i,
  input  logic                    fb_we_i,
  input  logic [SLOT_W-1:0]       fb_addr_i,
  input  metf_pkg::metf_fb_rec_t  fb_data_i,
  input  logic                    set_we_i,
  input  logic [SLOT_W-1:0]       set_addr_i,
  input  metf_pkg::metf_set_rec_t set_data_i,
  output metf_pkg::metf_fb_rec_t  fb_data_o,
  output metf_pkg::metf_set_rec_t set_data_o
);

  metf_pkg::metf_fb_rec_t  fb_mem  [NSLOTS];
  metf_pkg::metf_set_rec_t set_mem [NSLOTS];
  metf_pkg::metf_fb_rec_t  fb_rd_q;
  metf_pkg::metf_set_rec_t set_rd_q;
  logic [NSLOTS-1:0]       fb_vld_q;
  logic [NSLOTS-1:0]       set_vld_q;
  logic                    fb_hit_q;
  logic                    set_hit_q;

  always_ff @(posedge clk_i) begin
    if (fb_we_i) begin
      fb_mem[fb_addr_i] <= fb_data_i;
    end
    if (set_we_i) begin
      set_mem[set_addr_i] <= set_data_i;
    end
    if (rd_en_i) begin
      fb_rd_q  <= fb_mem[rd_addr_i];
      set_rd_q <= set_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_vld_q  <= '0;
      set_vld_q <= '0;
      fb_hit_q  <= 1'b0;
      set_hit_q <= 1'b0;
    end else begin
      if (fb_we_i) begin
        fb_vld_q[fb_addr_i] <= 1'b1;
      end
      if (set_we_i) begin
        set_vld_q[set_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        fb_hit_q  <= fb_vld_q[rd_addr_i];
        set_hit_q <= set_vld_q[rd_addr_i];
      end
    end
  end

  assign fb_data_o  = fb_hit_q  ? fb_rd_q  : '0;
  assign set_data_o = set_hit_q ? set_rd_q : '0;

endmodule

`default_nettype wire

FILE: rtl/motor_encoder_feedback_tracker_top.sv
// Encoder feedback tracker: slot lookup, multi-turn unwrap, angle and speed.
// A feedback frame holds the input through its steps: accept, slot read, unwrap,
// six steps (angle, total, wrap, divide, reciprocal, quotient multiply) around the one
// shared 33x33 multiplier, then the output load, which waits while the output register is full.
// Setup items and frames for slots outside the table are taken without leaving idle.
// Async active-low reset restores register defaults and marks all slots zero.
`timescale 1ns / 1ps
`default_nettype none

module motor_encoder_feedback_tracker_top #(
  parameter int NUM_BUSES     = 3,
  parameter int SLOTS_PER_BUS = 11
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  metf_in_if.sink    item_i,
  metf_out_if.source result_o,
  metf_cfg_if.sink   cfg_i
);

  localparam int NSLOTS = NUM_BUSES * SLOTS_PER_BUS;
  localparam int SLOT_W = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;

  // Configuration
  logic [15:0] cpr_q;
  logic [23:0] dpc_q;
  logic [10:0] base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpr_q  <= metf_pkg::CPR_RESET;
      dpc_q  <= metf_pkg::DPC_RESET;
      base_q <= metf_pkg::BASE_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        metf_pkg::CFG_COUNTS_PER_REV:    cpr_q  <= cfg_i.data[15:0];
        metf_pkg::CFG_DEGREES_PER_COUNT: dpc_q  <= cfg_i.data;
        metf_pkg::CFG_BASE_CAN_ID:       base_q <= cfg_i.data[10:0];
        default: ;
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;

  // Slot decode
  logic [10:0]       idx_full;
  logic              slot_hit;
  logic [SLOT_W-1:0] slot_in;
  logic              item_acc;
  logic [15:0]       rpm_abs;

  assign idx_full = item_i.can_id - base_q;
  assign slot_hit = ({2'b00, item_i.bus} < 4'(NUM_BUSES)) && (item_i.can_id >= base_q)
                    && (idx_full < 11'(SLOTS_PER_BUS));
  assign slot_in  = SLOT_W'(int'(item_i.bus) * SLOTS_PER_BUS + int'(idx_full[3:0]));
  assign item_acc = item_i.valid && item_i.ready;
  assign rpm_abs  = item_i.rotor_rpm[15] ? 16'(16'd0 - item_i.rotor_rpm) : item_i.rotor_rpm;

  // Datapath registers
  metf_pkg::metf_state_e state_q, state_d;
  logic [1:0]            bus_q;
  logic [3:0]            idx_q;
  logic [SLOT_W-1:0]     slot_q;
  logic [12:0]           pos_q;
  logic [15:0]           rpm_q;
  logic [15:0]           cur_q;
  logic [7:0]            temp_q;
  logic [23:0]           mag_q;
  logic [31:0]           cnt_q;
  metf_pkg::metf_kind_e  kind_q;
  logic [31:0]           zero_q;
  logic [23:0]           spd_q;
  logic [47:0]           ta_q;
  logic [48:0]           d_q;
  logic [30:0]           y_q;

  // Store and multiplier hookup
  logic                    rd_en, fb_we, set_we, load_out, item_ready, mul_en;
  metf_pkg::metf_fb_rec_t  fb_wr, fb_rd;
  metf_pkg::metf_set_rec_t set_wr, set_rd;
  logic signed [32:0]      mul_a, mul_b;
  logic signed [65:0]      prod;

  metf_store #(
    .NSLOTS (NSLOTS),
    .SLOT_W (SLOT_W)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_addr_i  (slot_q),
    .fb_we_i    (fb_we),
    .fb_addr_i  (slot_q),
    .fb_data_i  (fb_wr),
    .set_we_i   (set_we),
    .set_addr_i (slot_in),
    .set_data_i (set_wr),
    .fb_data_o  (fb_rd),
    .set_data_o (set_rd)
  );

  metf_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // Unwrap against the stored position
  logic        wrap_up, wrap_dn;
  logic [31:0] cpr32, last32, pos32, cnt_new;

  assign cpr32   = {16'd0, cpr_q};
  assign last32  = {19'd0, fb_rd.pos};
  assign pos32   = {19'd0, pos_q};
  assign wrap_up = (fb_rd.pos > metf_pkg::EDGE_HIGH) && (pos_q < metf_pkg::EDGE_LOW);
  assign wrap_dn = (fb_rd.pos < metf_pkg::EDGE_LOW) && (pos_q > metf_pkg::EDGE_HIGH);

  always_comb begin
    if (wrap_up) begin
      cnt_new = fb_rd.cnt + (cpr32 - last32) + pos32;
    end else if (wrap_dn) begin
      cnt_new = fb_rd.cnt - ((cpr32 - pos32) + last32);
    end else begin
      cnt_new = fb_rd.cnt + pos32 - last32;
    end
  end

  always_comb begin
    fb_wr.pos   = pos_q;
    fb_wr.cnt   = cnt_new;
    set_wr.kind = metf_pkg::metf_kind_e'(item_i.motor_kind);
    set_wr.zero = item_i.zero_deg;
  end

  // Ratio speed dividend, rounded half up on magnitude
  logic [23:0] spd_num;
  logic [31:0] spd_recip;

  assign spd_num   = mag_q + ((set_rd.kind == metf_pkg::KIND_RATIO36) ?
                              metf_pkg::ROUND36 : metf_pkg::ROUND19);
  assign spd_recip = (set_rd.kind == metf_pkg::KIND_RATIO36) ?
                     metf_pkg::RECIP36 : metf_pkg::RECIP19;

  logic [23:0] spd_quo, spd_sgn, spd_d;

  assign spd_quo = (kind_q == metf_pkg::KIND_RATIO36) ? prod[metf_pkg::SHIFT36 +: 24]
                                                      : prod[metf_pkg::SHIFT19 +: 24];
  assign spd_sgn = rpm_q[15] ? 24'(24'd0 - spd_quo) : spd_quo;

  always_comb begin
    case (kind_q)
      metf_pkg::KIND_DIRECT:  spd_d = {rpm_q, 8'h00};
      metf_pkg::KIND_RATIO19,
      metf_pkg::KIND_RATIO36: spd_d = spd_sgn;
      default:                spd_d = '0;
    endcase
  end

  // Angle arithmetic
  logic [55:0] ta_round;
  logic [48:0] d_d;
  logic [30:0] y_d;
  logic [30:0] rem_full;
  logic [24:0] wrapped;
  logic [25:0] rel_w;

  assign ta_round = prod[55:0] + 56'd128;
  assign d_d      = {ta_q[47], ta_q} - {{17{zero_q[31]}}, zero_q}
                    + 49'(metf_pkg::HALF_TURN_Q16);
  assign y_d      = {d_q[48], d_q[48:metf_pkg::FRAC_W]} + metf_pkg::MOD_OFFSET;
  assign rem_full = y_q - prod[30:0];
  assign wrapped  = {rem_full[5:0], d_q[metf_pkg::FRAC_W-1:0]};
  assign rel_w    = {1'b0, wrapped} - 26'(metf_pkg::HALF_TURN_Q16);

  // Sequencer
  logic out_valid_q;
  logic out_free;

  assign out_free = !out_valid_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= metf_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      metf_pkg::S_IDLE: begin
        if (item_acc && slot_hit && (item_i.op == metf_pkg::OP_FEEDBACK)) begin
          state_d = metf_pkg::S_READ;
        end
      end
      metf_pkg::S_READ:   state_d = metf_pkg::S_UNWRAP;
      metf_pkg::S_UNWRAP: state_d = metf_pkg::S_ANGLE;
      metf_pkg::S_ANGLE:  state_d = metf_pkg::S_TOTAL;
      metf_pkg::S_TOTAL:  state_d = metf_pkg::S_WRAP;
      metf_pkg::S_WRAP:   state_d = metf_pkg::S_DIV;
      metf_pkg::S_DIV:    state_d = metf_pkg::S_RECIP;
      metf_pkg::S_RECIP:  state_d = metf_pkg::S_QMUL;
      metf_pkg::S_QMUL:   state_d = metf_pkg::S_FINISH;
      metf_pkg::S_FINISH: begin
        if (out_free) begin
          state_d = metf_pkg::S_IDLE;
        end
      end
      default: state_d = metf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    item_ready = 1'b0;
    rd_en      = 1'b0;
    fb_we      = 1'b0;
    set_we     = 1'b0;
    load_out   = 1'b0;
    mul_en     = 1'b1;
    mul_a      = '0;
    mul_b      = '0;
    case (state_q)
      metf_pkg::S_IDLE: begin
        item_ready = 1'b1;
        set_we     = item_i.valid && slot_hit && (item_i.op == metf_pkg::OP_SETUP);
      end
      metf_pkg::S_READ: begin
        rd_en = 1'b1;
      end
      metf_pkg::S_UNWRAP: begin
        fb_we = 1'b1;
        mul_a = {9'd0, spd_num};
        mul_b = {1'b0, spd_recip};
      end
      metf_pkg::S_ANGLE: begin
        mul_a = {cnt_q[31], cnt_q};
        mul_b = {9'd0, dpc_q};
      end
      metf_pkg::S_RECIP: begin
        mul_a = {2'b00, y_q};
        mul_b = {1'b0, metf_pkg::RECIP45};
      end
      metf_pkg::S_QMUL: begin
        // floor(y / 45) from the reciprocal product
        mul_a = {7'd0, prod[metf_pkg::SHIFT45 +: 26]};
        mul_b = {27'd0, metf_pkg::MOD_DIV};
      end
      metf_pkg::S_FINISH: begin
        // keep q * 45 while the output register is busy
        mul_en   = 1'b0;
        load_out = out_free;
      end
      default: ;
    endcase
  end

  assign item_i.ready = item_ready;

  always_ff @(posedge clk_i) begin
    if (item_acc) begin
      bus_q  <= item_i.bus;
      idx_q  <= idx_full[3:0];
      slot_q <= slot_in;
      pos_q  <= item_i.encoder_position;
      rpm_q  <= item_i.rotor_rpm;
      cur_q  <= item_i.current;
      temp_q <= item_i.temperature;
      mag_q  <= {rpm_abs, 8'h00};
    end
    if (state_q == metf_pkg::S_UNWRAP) begin
      cnt_q  <= cnt_new;
      kind_q <= set_rd.kind;
      zero_q <= set_rd.zero;
    end
    if (state_q == metf_pkg::S_ANGLE) begin
      spd_q <= spd_d;
    end
    if (state_q == metf_pkg::S_TOTAL) begin
      ta_q <= ta_round[55:8];
    end
    if (state_q == metf_pkg::S_WRAP) begin
      d_q <= d_d;
    end
    if (state_q == metf_pkg::S_DIV) begin
      y_q <= y_d;
    end
  end

  // Output register
  logic [1:0]  o_bus_q;
  logic [3:0]  o_idx_q;
  logic [31:0] o_cnt_q;
  logic [47:0] o_ta_q;
  logic [24:0] o_rel_q;
  logic [23:0] o_spd_q;
  logic [15:0] o_rpm_q;
  logic [15:0] o_cur_q;
  logic [7:0]  o_temp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      o_bus_q  <= bus_q;
      o_idx_q  <= idx_q;
      o_cnt_q  <= cnt_q;
      o_ta_q   <= ta_q;
      o_rel_q  <= (kind_q == metf_pkg::KIND_DIRECT) ? rel_w[24:0] : '0;
      o_spd_q  <= spd_q;
      o_rpm_q  <= rpm_q;
      o_cur_q  <= cur_q;
      o_temp_q <= temp_q;
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.out_bus         = o_bus_q;
  assign result_o.motor_index     = o_idx_q;
  assign result_o.turn_count      = o_cnt_q;
  assign result_o.total_angle     = o_ta_q;
  assign result_o.relative_angle  = o_rel_q;
  assign result_o.shaft_speed     = o_spd_q;
  assign result_o.out_rotor_rpm   = o_rpm_q;
  assign result_o.out_current     = o_cur_q;
  assign result_o.out_temperature = o_temp_q;

endmodule

`default_nettype wire

FILE: rtl/metf_checker.sv
// Port-level checks for the tracker top level, attached by bind.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module metf_checker #(
  parameter int NUM_BUSES     = 3,
  parameter int SLOTS_PER_BUS = 11
) (
  input logic        clk_i,
  input logic        rst_ni,
  metf_in_if.sink    item_i,
  metf_out_if.source result_o
);

  // Setup transfers never stall the input side
  `ASSERT_NEXT(a_setup_ready, clk_i, rst_ni, item_i.valid && item_i.ready && (item_i.op == metf_pkg::OP_SETUP), item_i.ready)

  // Results only name slots that exist
  `ASSERT_IMPL(a_slot_range, clk_i, rst_ni, result_o.valid, ({1'b0, result_o.motor_index} < 5'(SLOTS_PER_BUS)) && ({2'b00, result_o.out_bus} < 4'(NUM_BUSES)))

  // Relative angle lies within half a turn
  `ASSERT_IMPL(a_rel_range, clk_i, rst_ni, result_o.valid, (result_o.relative_angle >= -metf_pkg::HALF_TURN_Q16) && (result_o.relative_angle < metf_pkg::HALF_TURN_Q16))

  // A stalled result holds
  `ASSERT_NEXT(a_result_hold, clk_i, rst_ni, result_o.valid && !result_o.ready, result_o.valid && $stable(result_o.turn_count) && $stable(result_o.total_angle))

endmodule

bind motor_encoder_feedback_tracker_top metf_checker #(
  .NUM_BUSES     (NUM_BUSES),
  .SLOTS_PER_BUS (SLOTS_PER_BUS)
) u_metf_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .item_i   (item_i),
  .result_o (result_o)
);

`default_nettype wire
